// ===== rtl/odrc_pkg.sv =====
package odrc_pkg;

  // panel geometry
  localparam int COLUMNS   = 128;
  localparam int ROWS      = 64;
  localparam int PAGES     = ROWS / 8;
  localparam int RAM_BYTES = COLUMNS * ROWS / 8;
  localparam int AW        = $clog2(RAM_BYTES);
  // page * COLUMNS + column over 8-bit counters
  localparam int IDX_W     = 16;

  // payload widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int PAGE_W = 3;
  localparam int COL_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_e;

  // control bytes
  localparam logic [7:0] CTRL_COMMAND = 8'h80;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // opcodes
  localparam logic [7:0] OP_COL_WINDOW  = 8'h21;
  localparam logic [7:0] OP_PAGE_WINDOW = 8'h22;
  localparam logic [7:0] OP_PANEL_OFF   = 8'hAE;
  localparam logic [7:0] OP_PANEL_ON    = 8'hAF;
  localparam logic [7:0] OP_CONTRAST    = 8'h81;
  localparam logic [7:0] OP_MUX_RATIO   = 8'hA8;
  localparam logic [7:0] OP_DISP_OFFSET = 8'hD3;
  localparam logic [7:0] OP_CLOCK_DIV   = 8'hD5;
  localparam logic [7:0] OP_PRECHARGE   = 8'hD9;
  localparam logic [7:0] OP_VCOM_LEVEL  = 8'hDB;
  localparam logic [7:0] OP_CHARGE_PUMP = 8'h8D;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] byte_in;
    logic [PAGE_W-1:0] scan_page;
    logic [COL_W-1:0]  scan_column;
  } item_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [AW-1:0]     addr;
    logic [BYTE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic panel_on;
    logic frame_dump;
    logic scan_hit;
  } item_info_t;

  function automatic logic one_arg_setting(input logic [7:0] op);
    return op == OP_CONTRAST || op == OP_MUX_RATIO || op == OP_DISP_OFFSET ||
           op == OP_CLOCK_DIV || op == OP_PRECHARGE || op == OP_VCOM_LEVEL ||
           op == OP_CHARGE_PUMP;
  endfunction

endpackage

// ===== rtl/odrc_if.sv =====
interface odrc_in_if import odrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] byte_in;
  logic [PAGE_W-1:0] scan_page;
  logic [COL_W-1:0]  scan_column;

  modport source(output valid, cmd, byte_in, scan_page, scan_column, input ready);
  modport sink(input valid, cmd, byte_in, scan_page, scan_column, output ready);
endinterface

interface odrc_out_if import odrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] scan_data;
  logic              panel_on;
  logic              frame_dump;

  modport source(output valid, scan_data, panel_on, frame_dump, input ready);
  modport sink(input valid, scan_data, panel_on, frame_dump, output ready);
endinterface

// ===== rtl/odrc_ram.sv =====
module odrc_ram import odrc_pkg::*; (
  input  logic              clk,
  input  ram_req_t          req,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [RAM_BYTES];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== rtl/odrc_ctrl.sv =====
module odrc_ctrl import odrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  output logic       busy,
  output ram_req_t   ram_req,
  output item_info_t info
);

  logic          expecting_control, expecting_control_next;
  logic [7:0]    control_byte, control_byte_next;
  logic [7:0]    cur_page, cur_page_next;
  logic [7:0]    cur_column, cur_column_next;
  logic [7:0]    win_page_first, win_page_first_next;
  logic [7:0]    win_page_last, win_page_last_next;
  logic [7:0]    win_col_first, win_col_first_next;
  logic [7:0]    win_col_last, win_col_last_next;
  logic          display_enabled, display_enabled_next;
  logic          arg_pending, arg_pending_next;
  logic [7:0]    pending_opcode, pending_opcode_next;
  logic          arg_count, arg_count_next;
  logic [AW-1:0] clr_addr;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] scan_idx;
  logic [7:0]    col_inc;
  logic [7:0]    page_inc;
  logic          dump;
  logic [7:0]    b;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      expecting_control <= 1'b1;
      control_byte      <= '0;
      cur_page          <= '0;
      cur_column        <= '0;
      win_page_first    <= '0;
      win_page_last     <= 8'(PAGES - 1);
      win_col_first     <= '0;
      win_col_last      <= 8'(COLUMNS - 1);
      display_enabled   <= 1'b0;
      arg_pending       <= 1'b0;
      pending_opcode    <= '0;
      arg_count         <= 1'b0;
    end else begin
      expecting_control <= expecting_control_next;
      control_byte      <= control_byte_next;
      cur_page          <= cur_page_next;
      cur_column        <= cur_column_next;
      win_page_first    <= win_page_first_next;
      win_page_last     <= win_page_last_next;
      win_col_first     <= win_col_first_next;
      win_col_last      <= win_col_last_next;
      display_enabled   <= display_enabled_next;
      arg_pending       <= arg_pending_next;
      pending_opcode    <= pending_opcode_next;
      arg_count         <= arg_count_next;
    end
  end

  // ram clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(RAM_BYTES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // decode of one bus event
  always_comb begin
    expecting_control_next = expecting_control;
    control_byte_next      = control_byte;
    cur_page_next          = cur_page;
    cur_column_next        = cur_column;
    win_page_first_next    = win_page_first;
    win_page_last_next     = win_page_last;
    win_col_first_next     = win_col_first;
    win_col_last_next      = win_col_last;
    display_enabled_next   = display_enabled;
    arg_pending_next       = arg_pending;
    pending_opcode_next    = pending_opcode;
    arg_count_next         = arg_count;
    dump                   = 1'b0;
    ram_req                = '0;
    info                   = '0;
    b        = item.byte_in;
    wr_idx   = IDX_W'(cur_page) * IDX_W'(COLUMNS) + IDX_W'(cur_column);
    scan_idx = IDX_W'(item.scan_page) * IDX_W'(COLUMNS) + IDX_W'(item.scan_column);
    col_inc  = cur_column + 8'd1;
    page_inc = cur_page + 8'd1;

    if (busy) begin
      ram_req.we    = 1'b1;
      ram_req.addr  = clr_addr;
      ram_req.wdata = '0;
    end else if (accept) begin
      case (cmd_e'(item.cmd))
        CMD_START: begin
          expecting_control_next = 1'b1;
        end
        CMD_WRITE: begin
          if (expecting_control) begin
            control_byte_next      = b;
            expecting_control_next = 1'b0;
          end else if (control_byte == CTRL_COMMAND) begin
            if (arg_pending) begin
              // argument byte, whatever its value
              if (pending_opcode == OP_COL_WINDOW) begin
                if (!arg_count) begin
                  win_col_first_next = b;
                  cur_column_next    = b;
                  arg_count_next     = 1'b1;
                end else begin
                  win_col_last_next = b;
                  arg_pending_next  = 1'b0;
                end
              end else if (pending_opcode == OP_PAGE_WINDOW) begin
                if (!arg_count) begin
                  win_page_first_next = b;
                  cur_page_next       = b;
                  arg_count_next      = 1'b1;
                end else begin
                  win_page_last_next = b;
                  arg_pending_next   = 1'b0;
                end
              end else begin
                arg_pending_next = 1'b0;
              end
            end else if (b == OP_PANEL_OFF) begin
              display_enabled_next = 1'b0;
            end else if (b == OP_PANEL_ON) begin
              display_enabled_next = 1'b1;
              dump                 = 1'b1;
            end else if (b == OP_COL_WINDOW || b == OP_PAGE_WINDOW || one_arg_setting(b)) begin
              pending_opcode_next = b;
              arg_count_next      = 1'b0;
              arg_pending_next    = 1'b1;
            end
          end else if (control_byte == CTRL_DATA) begin
            // store, then advance column and page within the window
            if (wr_idx < IDX_W'(RAM_BYTES)) begin
              ram_req.we    = 1'b1;
              ram_req.addr  = wr_idx[AW-1:0];
              ram_req.wdata = b;
            end
            if (col_inc > win_col_last) begin
              cur_column_next = win_col_first;
              if (page_inc > win_page_last) begin
                cur_page_next = win_page_first;
                dump          = display_enabled;
              end else begin
                cur_page_next = page_inc;
              end
            end else begin
              cur_column_next = col_inc;
            end
          end
        end
        CMD_SCAN: begin
          if (scan_idx < IDX_W'(RAM_BYTES)) begin
            ram_req.re    = 1'b1;
            ram_req.addr  = scan_idx[AW-1:0];
            info.scan_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    info.panel_on   = display_enabled_next;
    info.frame_dump = dump;
  end

endmodule

// ===== rtl/odrc_out.sv =====
module odrc_out import odrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  item_info_t        info,
  input  logic [BYTE_W-1:0] rdata,
  output logic              take,
  odrc_out_if.source        result
);

  logic       s1_valid;
  item_info_t s1_info;
  logic       s1_fwd;

  assign s1_fwd = s1_valid && (!result.valid || result.ready);
  assign take   = !s1_valid || s1_fwd;

  // stage aligned with ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (take && accept) begin
      s1_info <= info;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_fwd) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fwd) begin
      result.scan_data  <= s1_info.scan_hit ? rdata : '0;
      result.panel_on   <= s1_info.panel_on;
      result.frame_dump <= s1_info.frame_dump;
    end
  end

endmodule

// ===== rtl/oled_display_ram_controller_unit.sv =====
// path: ram read data and item info are registered, then the output register
// throughput: one item per cycle while the output is not stalled; each item
//   makes at most one access to the single-port display ram; read is registered
// reset: synchronous; control state returns to its power-on values and a
//   sweep zeroes all 1024 ram bytes, input ready stays low meanwhile
module oled_display_ram_controller_unit import odrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  odrc_in_if.sink    item,
  odrc_out_if.source result
);

  item_t             item_pl;
  logic              accept;
  logic              take;
  logic              busy;
  ram_req_t          ram_req;
  item_info_t        info;
  logic [BYTE_W-1:0] rdata;

  assign item_pl    = '{cmd: item.cmd, byte_in: item.byte_in,
                        scan_page: item.scan_page, scan_column: item.scan_column};
  assign item.ready = !busy && take;
  assign accept     = item.valid && item.ready;

  odrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item_pl),
    .busy    (busy),
    .ram_req (ram_req),
    .info    (info)
  );

  odrc_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  odrc_out u_out (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .info   (info),
    .rdata  (rdata),
    .take   (take),
    .result (result)
  );

  // a frame dump comes from a write beat, never from a scan read
  a_dump_no_scan: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_dump |-> result.scan_data == '0)
    else $error("frame dump beat carries scan data");

  // one ram access per cycle
  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("ram read and write in the same cycle");

  // nothing is accepted during the clearing sweep
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> !result.valid)
    else $error("result beat pending at end of ram clear");

endmodule
